FILE: src/pfa_pkg.sv
// ----------------------------------------------------------------------------
// pfa_pkg
// Shared constants, codes and control types of the paged frame allocator.
// ----------------------------------------------------------------------------
package pfa_pkg;

	localparam int OFFSET_BITS = 10;
	localparam int VADDR_BITS  = 20;
	localparam int VPN_BITS    = VADDR_BITS - OFFSET_BITS;
	localparam int VPAGES      = 1 << VPN_BITS;
	localparam int FRAME_BYTES = 1 << OFFSET_BITS;
	localparam int NUM_FRAMES  = 1024;
	localparam int FRAME_BITS  = $clog2(NUM_FRAMES);
	localparam int FNUM_BITS   = FRAME_BITS + 1;
	localparam int MAX_PROCS   = 16;
	localparam int PID_BITS    = 4;
	localparam int MAP_AW      = PID_BITS + VPN_BITS;
	localparam int PHYS_AW     = FRAME_BITS + OFFSET_BITS;
	localparam int BRK_BITS    = VADDR_BITS + 1;
	localparam int SIZE_BITS   = 21;
	localparam int REQ_BITS    = SIZE_BITS - OFFSET_BITS + 1;
	localparam int CNT_BITS    = FRAME_BITS + 1;
	localparam int D_BITS      = CNT_BITS + 1;
	localparam int CLR_BITS    = (PHYS_AW > MAP_AW) ? PHYS_AW : MAP_AW;
	localparam int DATA_BITS   = 8;

	typedef enum logic [1:0] {
		CMD_ALLOC = 2'd0,
		CMD_FREE  = 2'd1,
		CMD_READ  = 2'd2,
		CMD_WRITE = 2'd3
	} cmd_t;

	typedef enum logic [4:0] {
		ST_CLEAR, ST_IDLE, ST_CHECK, ST_A_CNT, ST_A_MAP_INIT, ST_A_MAP, ST_A_FIN,
		ST_LOOK_W, ST_MEM_W, ST_WALK_RD, ST_WALK_WT, ST_SH_RD, ST_SH_WR, ST_ZERO,
		ST_DONE
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE, OP_CLEAR, OP_LOAD, OP_SCAN_INIT, OP_SCAN_CNT, OP_SCAN_MAP,
		OP_A_FIN, OP_LOOK, OP_TAKE_E, OP_MEM_CAP, OP_WALK_RD, OP_WALK_WT,
		OP_SH_RD, OP_SH_WR, OP_ZERO, OP_EMIT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} ctl_t;

	typedef struct packed {
		cmd_t cmd;
		logic clear_done;
		logic pid_bad;
		logic alloc_bad;
		logic scan_done;
		logic scan_short;
		logic e_bad;
		logic walk_end;
		logic sh_end;
		logic zero_end;
		logic out_busy;
	} sts_t;

endpackage

FILE: src/paged_frame_allocator_mmu_top.sv
// ----------------------------------------------------------------------------
// paged_frame_allocator_mmu_top
// Frame allocator with per-process page maps and a byte-wide physical memory.
// ----------------------------------------------------------------------------
// Requests enter on the s_axis channel, one item each, and every request
// yields exactly one result item on the m_axis channel.
// After reset the block runs a clearing pass over the data memory, the page
// maps and the frame owner table, one entry per cycle; s_axis_tready stays
// low until it completes.
// One request is worked on at a time. Allocate scans the frame owner table
// twice, first to count free frames and then to claim and map them, through
// its single read port. Free walks the next-frame chain, freeing each owned
// frame, then shifts the page map entries down and clears the ones above.
// A finished result sits in an output register; the next request is accepted
// while it waits. If the receiver stalls, the following result waits in the
// controller until the output register is free.
// ----------------------------------------------------------------------------
module paged_frame_allocator_mmu_top
	import pfa_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [55:0] s_axis_tdata,  // pid, size_bytes, vaddr, wdata, zero pad
	input  logic [1:0]  s_axis_tuser,  // cmd
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // head_addr, rdata, zero pad
	output logic [0:0]  m_axis_tuser   // status
);

	ctl_t ctl;
	sts_t sts;
	logic                  out_status;
	logic [VADDR_BITS-1:0] out_head;
	logic [DATA_BITS-1:0]  out_rdata;

	pfa_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.sts(sts), .ctl(ctl)
	);

	pfa_dp u_dp (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .sts(sts),
		.in_cmd(s_axis_tuser), .in_data(s_axis_tdata[52:0]),
		.out_ready(m_axis_tready), .out_valid(m_axis_tvalid),
		.out_status(out_status), .out_head(out_head), .out_rdata(out_rdata)
	);

	assign m_axis_tdata = {4'b0000, out_rdata, out_head};
	assign m_axis_tuser = out_status;

endmodule

FILE: src/pfa_ram.sv
// ----------------------------------------------------------------------------
// pfa_ram
// Generic memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module pfa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: src/pfa_dp.sv
// ----------------------------------------------------------------------------
// pfa_dp
// Datapath: tables, break pointers, scan and walk counters, result register.
// ----------------------------------------------------------------------------
module pfa_dp
	import pfa_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  ctl_t        ctl,
	output sts_t        sts,
	input  logic [1:0]  in_cmd,
	input  logic [52:0] in_data,
	input  logic        out_ready,
	output logic        out_valid,
	output logic        out_status,
	output logic [VADDR_BITS-1:0] out_head,
	output logic [DATA_BITS-1:0]  out_rdata
);

	// Request registers.
	cmd_t                  cmd_q;
	logic [PID_BITS-1:0]   pid_q;
	logic [VADDR_BITS-1:0] va_q;
	logic [DATA_BITS-1:0]  wd_q;
	logic [REQ_BITS-1:0]   req_q;

	logic [BRK_BITS-1:0]   brk_q [MAX_PROCS];
	logic [CLR_BITS-1:0]   clr_q;
	logic [CNT_BITS-1:0]   scan_addr_q;
	logic                  scan_vld_s1;
	logic [FRAME_BITS-1:0] scan_idx_s1;
	logic [CNT_BITS-1:0]   cnt_q;
	logic [FRAME_BITS-1:0] prev_q;
	logic                  have_prev_q;
	logic [FNUM_BITS-1:0]  cur_q;
	logic [CNT_BITS-1:0]   n_q;
	logic [D_BITS-1:0]     d_q;

	logic                  res_fail_q;
	logic [VADDR_BITS-1:0] res_head_q;
	logic [DATA_BITS-1:0]  res_rdata_q;
	logic                  out_valid_q;
	logic                  out_status_q;
	logic [VADDR_BITS-1:0] out_head_q;
	logic [DATA_BITS-1:0]  out_rdata_q;

	// Memory ports.
	logic                  own_we;
	logic [FRAME_BITS-1:0] own_waddr, own_raddr;
	logic [PID_BITS-1:0]   own_wdata, own_rdata;
	logic                  nxt_we;
	logic [FRAME_BITS-1:0] nxt_waddr, nxt_raddr;
	logic [FNUM_BITS-1:0]  nxt_wdata, nxt_rdata;
	logic                  map_we;
	logic [MAP_AW-1:0]     map_waddr, map_raddr;
	logic [FNUM_BITS-1:0]  map_wdata, map_rdata;
	logic                  dat_we;
	logic [PHYS_AW-1:0]    dat_waddr, dat_raddr;
	logic [DATA_BITS-1:0]  dat_wdata, dat_rdata;

	logic [BRK_BITS-1:0]   bp;
	logic [CNT_BITS-1:0]   bpage;
	logic [REQ_BITS-1:0]   room;
	logic                  scan_more;
	logic                  scan_hit;
	logic                  e_bad;
	logic [FRAME_BITS-1:0] e_idx;
	logic [FRAME_BITS-1:0] cur_idx;
	logic [PHYS_AW-1:0]    phys;
	logic                  walk_end;
	logic [D_BITS-1:0]     dn;
	logic [D_BITS-1:0]     lo;
	logic [VPN_BITS-1:0]   vp;
	logic [VPN_BITS-1:0]   map_slot;

	pfa_ram #(.WIDTH(PID_BITS), .DEPTH(NUM_FRAMES)) u_owner (
		.clk(clk), .we(own_we), .waddr(own_waddr), .wdata(own_wdata),
		.raddr(own_raddr), .rdata(own_rdata)
	);

	pfa_ram #(.WIDTH(FNUM_BITS), .DEPTH(NUM_FRAMES)) u_next (
		.clk(clk), .we(nxt_we), .waddr(nxt_waddr), .wdata(nxt_wdata),
		.raddr(nxt_raddr), .rdata(nxt_rdata)
	);

	pfa_ram #(.WIDTH(FNUM_BITS), .DEPTH(1 << MAP_AW)) u_map (
		.clk(clk), .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
		.raddr(map_raddr), .rdata(map_rdata)
	);

	pfa_ram #(.WIDTH(DATA_BITS), .DEPTH(1 << PHYS_AW)) u_data (
		.clk(clk), .we(dat_we), .waddr(dat_waddr), .wdata(dat_wdata),
		.raddr(dat_raddr), .rdata(dat_rdata)
	);

	assign bp        = brk_q[pid_q];
	assign bpage     = bp[BRK_BITS-1:OFFSET_BITS];
	assign room      = REQ_BITS'(VPAGES) - REQ_BITS'(bpage);
	assign scan_more = REQ_BITS'(cnt_q) < req_q;
	assign scan_hit  = scan_vld_s1 && (own_rdata == '0) && scan_more;
	assign e_bad     = (map_rdata == '0) || (map_rdata > FNUM_BITS'(NUM_FRAMES));
	assign e_idx     = FRAME_BITS'(map_rdata - FNUM_BITS'(1));
	assign cur_idx   = FRAME_BITS'(cur_q - FNUM_BITS'(1));
	assign phys      = {e_idx, va_q[OFFSET_BITS-1:0]};
	assign walk_end  = (cur_q == '0) || (cur_q > FNUM_BITS'(NUM_FRAMES)) ||
		(n_q == CNT_BITS'(NUM_FRAMES));
	assign dn        = d_q + D_BITS'(n_q);
	assign lo        = (D_BITS'(n_q) >= D_BITS'(bpage)) ? '0 : D_BITS'(bpage) - D_BITS'(n_q);
	assign vp        = va_q[VADDR_BITS-1:OFFSET_BITS];
	assign map_slot  = VPN_BITS'(bpage) + VPN_BITS'(cnt_q);

	always_comb begin
		sts.cmd        = cmd_q;
		sts.clear_done = (clr_q == '1);
		sts.pid_bad    = (pid_q == '0) || (32'(pid_q) >= MAX_PROCS);
		sts.alloc_bad  = bp[VADDR_BITS] || (req_q > room) ||
			(req_q > REQ_BITS'(NUM_FRAMES));
		sts.scan_done  = !scan_more ||
			((scan_addr_q == CNT_BITS'(NUM_FRAMES)) && !scan_vld_s1);
		sts.scan_short = scan_more;
		sts.e_bad      = e_bad;
		sts.walk_end   = walk_end;
		sts.sh_end     = dn >= D_BITS'(bpage);
		sts.zero_end   = d_q >= D_BITS'(bpage);
		sts.out_busy   = out_valid_q && !out_ready;
	end

	always_comb begin
		own_we    = 1'b0;
		own_waddr = '0;
		own_wdata = '0;
		own_raddr = scan_addr_q[FRAME_BITS-1:0];
		nxt_we    = 1'b0;
		nxt_waddr = prev_q;
		nxt_wdata = '0;
		nxt_raddr = cur_idx;
		map_we    = 1'b0;
		map_waddr = {pid_q, d_q[VPN_BITS-1:0]};
		map_wdata = '0;
		map_raddr = {pid_q, vp};
		dat_we    = 1'b0;
		dat_waddr = phys;
		dat_wdata = wd_q;
		dat_raddr = phys;
		case (ctl.op)
			OP_CLEAR: begin
				own_we    = 1'b1;
				own_waddr = clr_q[FRAME_BITS-1:0];
				map_we    = 1'b1;
				map_waddr = clr_q[MAP_AW-1:0];
				dat_we    = 1'b1;
				dat_waddr = clr_q[PHYS_AW-1:0];
				dat_wdata = '0;
			end
			OP_SCAN_MAP: begin
				if (scan_hit) begin
					own_we    = 1'b1;
					own_waddr = scan_idx_s1;
					own_wdata = pid_q;
					map_we    = 1'b1;
					map_waddr = {pid_q, map_slot};
					map_wdata = FNUM_BITS'(scan_idx_s1) + FNUM_BITS'(1);
					nxt_we    = have_prev_q;
					nxt_wdata = FNUM_BITS'(scan_idx_s1) + FNUM_BITS'(1);
				end
			end
			OP_A_FIN: begin
				nxt_we = have_prev_q;
			end
			OP_TAKE_E: begin
				dat_we = (cmd_q == CMD_WRITE) && !e_bad;
			end
			OP_WALK_RD: begin
				if (!walk_end) begin
					own_we    = 1'b1;
					own_waddr = cur_idx;
				end
			end
			OP_SH_RD: begin
				map_raddr = {pid_q, dn[VPN_BITS-1:0]};
			end
			OP_SH_WR: begin
				map_we    = 1'b1;
				map_wdata = map_rdata;
			end
			OP_ZERO: begin
				map_we = !sts.zero_end;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < MAX_PROCS; p++) begin
				brk_q[p] <= '0;
			end
			clr_q       <= '0;
			scan_vld_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.op == OP_EMIT) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (ctl.op)
				OP_CLEAR: begin
					clr_q <= clr_q + CLR_BITS'(1);
				end
				OP_SCAN_INIT: begin
					scan_vld_s1 <= 1'b0;
				end
				OP_SCAN_CNT, OP_SCAN_MAP: begin
					scan_vld_s1 <= scan_addr_q < CNT_BITS'(NUM_FRAMES);
				end
				OP_A_FIN: begin
					brk_q[pid_q] <= bp + (BRK_BITS'(req_q) << OFFSET_BITS);
				end
				OP_ZERO: begin
					if (sts.zero_end) begin
						brk_q[pid_q] <= BRK_BITS'(lo) << OFFSET_BITS;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ctl.op)
			OP_LOAD: begin
				cmd_q       <= cmd_t'(in_cmd);
				pid_q       <= in_data[3:0];
				req_q       <= REQ_BITS'((22'(in_data[24:4]) + 22'(FRAME_BYTES - 1))
					>> OFFSET_BITS);
				va_q        <= in_data[44:25];
				wd_q        <= in_data[52:45];
				res_fail_q  <= 1'b1;
				res_head_q  <= '0;
				res_rdata_q <= '0;
			end
			OP_SCAN_INIT: begin
				scan_addr_q <= '0;
				cnt_q       <= '0;
				have_prev_q <= 1'b0;
			end
			OP_SCAN_CNT, OP_SCAN_MAP: begin
				if (scan_addr_q < CNT_BITS'(NUM_FRAMES)) begin
					scan_addr_q <= scan_addr_q + CNT_BITS'(1);
					scan_idx_s1 <= scan_addr_q[FRAME_BITS-1:0];
				end
				if (scan_hit) begin
					cnt_q <= cnt_q + CNT_BITS'(1);
					if (ctl.op == OP_SCAN_MAP) begin
						prev_q      <= scan_idx_s1;
						have_prev_q <= 1'b1;
					end
				end
			end
			OP_A_FIN: begin
				res_fail_q <= 1'b0;
				res_head_q <= bp[VADDR_BITS-1:0];
			end
			OP_TAKE_E: begin
				cur_q      <= map_rdata;
				n_q        <= '0;
				res_fail_q <= e_bad;
			end
			OP_MEM_CAP: begin
				res_rdata_q <= dat_rdata;
			end
			OP_WALK_RD: begin
				if (!walk_end) begin
					n_q <= n_q + CNT_BITS'(1);
				end else begin
					d_q <= D_BITS'(vp);
				end
			end
			OP_WALK_WT: begin
				cur_q <= nxt_rdata;
			end
			OP_SH_RD: begin
				if (sts.sh_end) begin
					d_q <= lo;
				end
			end
			OP_SH_WR, OP_ZERO: begin
				d_q <= d_q + D_BITS'(1);
			end
			OP_EMIT: begin
				out_status_q <= res_fail_q;
				out_head_q   <= res_head_q;
				out_rdata_q  <= res_rdata_q;
			end
			default: begin
			end
		endcase
	end

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_head   = out_head_q;
	assign out_rdata  = out_rdata_q;

endmodule

FILE: src/pfa_ctrl.sv
// ----------------------------------------------------------------------------
// pfa_ctrl
// Controller: sequences clearing, allocate, free, read and write.
// ----------------------------------------------------------------------------
module pfa_ctrl
	import pfa_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output ctl_t ctl
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		ctl.op   = OP_NONE;
		in_ready = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				ctl.op = OP_CLEAR;
				if (sts.clear_done) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.op  = OP_LOAD;
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (sts.pid_bad) begin
					state_d = ST_DONE;
				end else if (sts.cmd == CMD_ALLOC) begin
					if (sts.alloc_bad) begin
						state_d = ST_DONE;
					end else begin
						ctl.op  = OP_SCAN_INIT;
						state_d = ST_A_CNT;
					end
				end else begin
					ctl.op  = OP_LOOK;
					state_d = ST_LOOK_W;
				end
			end
			ST_A_CNT: begin
				ctl.op = OP_SCAN_CNT;
				if (sts.scan_done) begin
					state_d = sts.scan_short ? ST_DONE : ST_A_MAP_INIT;
				end
			end
			ST_A_MAP_INIT: begin
				ctl.op  = OP_SCAN_INIT;
				state_d = ST_A_MAP;
			end
			ST_A_MAP: begin
				ctl.op = OP_SCAN_MAP;
				if (sts.scan_done) state_d = ST_A_FIN;
			end
			ST_A_FIN: begin
				ctl.op  = OP_A_FIN;
				state_d = ST_DONE;
			end
			ST_LOOK_W: begin
				ctl.op = OP_TAKE_E;
				if (sts.e_bad) begin
					state_d = ST_DONE;
				end else begin
					case (sts.cmd)
						CMD_FREE:  state_d = ST_WALK_RD;
						CMD_READ:  state_d = ST_MEM_W;
						default:   state_d = ST_DONE;
					endcase
				end
			end
			ST_MEM_W: begin
				ctl.op  = OP_MEM_CAP;
				state_d = ST_DONE;
			end
			ST_WALK_RD: begin
				ctl.op  = OP_WALK_RD;
				state_d = sts.walk_end ? ST_SH_RD : ST_WALK_WT;
			end
			ST_WALK_WT: begin
				ctl.op  = OP_WALK_WT;
				state_d = ST_WALK_RD;
			end
			ST_SH_RD: begin
				ctl.op  = OP_SH_RD;
				state_d = sts.sh_end ? ST_ZERO : ST_SH_WR;
			end
			ST_SH_WR: begin
				ctl.op  = OP_SH_WR;
				state_d = ST_SH_RD;
			end
			ST_ZERO: begin
				ctl.op = OP_ZERO;
				if (sts.zero_end) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!sts.out_busy) begin
					ctl.op  = OP_EMIT;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule
